// ===== sv/mbb_pkg.sv =====
`default_nettype none

package mbb_pkg;

    localparam int INSTRUMENTS = 64;
    localparam int PRICE_BITS  = 32;

    localparam int IDX_W  = (INSTRUMENTS > 1) ? $clog2(INSTRUMENTS) : 1;
    localparam int INST_W = 6;
    localparam int MIN_W  = 11;
    localparam int VOL_W  = 32;
    localparam int PORT_PRICE_W = 32;

    // 23:58, 00:01, 03:00, 15:30
    localparam logic [MIN_W-1:0] WRAP_FROM = 11'd1438;
    localparam logic [MIN_W-1:0] WRAP_TO   = 11'd1;
    localparam logic [MIN_W-1:0] NIGHT_END = 11'd180;
    localparam logic [MIN_W-1:0] DAY_END   = 11'd930;

    typedef logic [PRICE_BITS-1:0] t_price;
    typedef logic [IDX_W-1:0]      t_idx;

    typedef struct packed {
        t_price             open;
        t_price             high;
        t_price             low;
        t_price             close;
        logic [VOL_W-1:0]   running;
        logic [VOL_W-1:0]   previous;
        logic [MIN_W-1:0]   open_min;
        logic [MIN_W-1:0]   close_min;
    } t_entry;

    typedef struct packed {
        t_price             price;
        logic [VOL_W-1:0]   volume;
        logic [MIN_W-1:0]   minute;
    } t_tick;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_WALK
    } t_state;

    localparam int ENTRY_W = $bits(t_entry);

    function automatic logic is_rollover(input logic [MIN_W-1:0] cur,
                                         input logic [MIN_W-1:0] t);
        logic later;
        logic blocked;
        later   = (cur < t) || ((cur >= WRAP_FROM) && (t <= WRAP_TO));
        blocked = (cur < NIGHT_END) && (t > DAY_END);
        return later && !blocked;
    endfunction

endpackage

`default_nettype wire

// ===== sv/mbb_ram.sv =====
`default_nettype none

module mbb_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [ADDR_W-1:0]        i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [ADDR_W-1:0]        i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/mbb_bar_calc.sv =====
`default_nettype none

module mbb_bar_calc (
    input  wire mbb_pkg::t_entry           i_entry,
    input  wire mbb_pkg::t_tick            i_tick,
    input  wire logic                      i_use_seed,
    output mbb_pkg::t_entry                o_base,
    output mbb_pkg::t_entry                o_update,
    output mbb_pkg::t_entry                o_reseed,
    output logic [mbb_pkg::VOL_W-1:0]      o_volume
);

    mbb_pkg::t_entry seed;
    mbb_pkg::t_entry base;
    mbb_pkg::t_entry upd;
    mbb_pkg::t_entry rsd;

    always_comb begin
        seed.open      = i_tick.price;
        seed.high      = i_tick.price;
        seed.low       = i_tick.price;
        seed.close     = i_tick.price;
        seed.running   = i_tick.volume;
        seed.previous  = i_tick.volume;
        seed.open_min  = i_tick.minute;
        seed.close_min = i_tick.minute;

        base = i_use_seed ? seed : i_entry;

        // same-minute update
        upd = base;
        upd.close = i_tick.price;
        if (i_tick.minute != base.open_min) begin
            upd.open     = i_tick.price;
            upd.open_min = i_tick.minute;
        end
        if (i_tick.price > base.high) begin
            upd.high = i_tick.price;
        end
        if (i_tick.price < base.low) begin
            upd.low = i_tick.price;
        end
        upd.running   = i_tick.volume;
        upd.close_min = i_tick.minute;

        // next period starts from close
        rsd = base;
        rsd.previous = base.running;
        rsd.open     = base.close;
        rsd.high     = base.close;
        rsd.low      = base.close;
        rsd.open_min = base.close_min;
    end

    assign o_base   = base;
    assign o_update = upd;
    assign o_reseed = rsd;
    assign o_volume = base.running - base.previous;

endmodule

`default_nettype wire

// ===== sv/per_instrument_minute_bar_builder_unit.sv =====
`default_nettype none

// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+------------------------------------------
// tick     | in        | start, busy            | i_instrument, i_tick_price,
//          |           |                        | i_tick_total_volume, i_tick_minute
// config   | in        | i_cfg_we               | i_cfg_wdata (start_minute)
// bar      | out       | o_bar_strobe           | o_bar_instrument .. o_bar_last
//
// a tick without rollover is accepted together with the bar memory read, then goes through
// a read-modify-write of that instrument's entry in the update state
// a rollover tick keeps busy high while the walk covers all INSTRUMENTS entries: it reads
// one entry per cycle through the single memory read port and emits one bar beat per cycle
// reset is synchronous; the seen bits clear at once, no clearing pass of the memory
// bar beats cannot be stalled; each shows on the outputs for exactly one cycle

module per_instrument_minute_bar_builder_unit (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic                                 i_cfg_we,
    input  wire logic [mbb_pkg::MIN_W-1:0]            i_cfg_wdata,
    input  wire logic [mbb_pkg::INST_W-1:0]           i_instrument,
    input  wire logic [mbb_pkg::PORT_PRICE_W-1:0]     i_tick_price,
    input  wire logic [mbb_pkg::VOL_W-1:0]            i_tick_total_volume,
    input  wire logic [mbb_pkg::MIN_W-1:0]            i_tick_minute,
    output logic                                      o_bar_strobe,
    output logic [mbb_pkg::INST_W-1:0]                o_bar_instrument,
    output logic [mbb_pkg::MIN_W-1:0]                 o_bar_minute,
    output logic [mbb_pkg::PORT_PRICE_W-1:0]          o_bar_open,
    output logic [mbb_pkg::PORT_PRICE_W-1:0]          o_bar_high,
    output logic [mbb_pkg::PORT_PRICE_W-1:0]          o_bar_low,
    output logic [mbb_pkg::PORT_PRICE_W-1:0]          o_bar_close,
    output logic [mbb_pkg::VOL_W-1:0]                 o_bar_volume,
    output logic                                      o_bar_seen,
    output logic                                      o_bar_last
);

    localparam mbb_pkg::t_idx LAST_IDX = mbb_pkg::IDX_W'(mbb_pkg::INSTRUMENTS - 1);

    mbb_pkg::t_state r_state, n_state;

    logic [mbb_pkg::INSTRUMENTS-1:0] r_seen, n_seen;
    logic [mbb_pkg::MIN_W-1:0]       r_cur, n_cur;
    mbb_pkg::t_idx                   r_idx, n_idx;
    mbb_pkg::t_tick                  r_tick, n_tick;
    mbb_pkg::t_idx                   r_tick_idx, n_tick_idx;
    logic                            r_seed_hit, n_seed_hit;
    logic                            r_was_seen, n_was_seen;
    logic                            r_same, n_same;

    logic                            r_bar_strobe, n_bar_strobe;
    logic [mbb_pkg::INST_W-1:0]      r_bar_instrument, n_bar_instrument;
    logic [mbb_pkg::MIN_W-1:0]       r_bar_minute, n_bar_minute;
    logic [mbb_pkg::PORT_PRICE_W-1:0] r_bar_open, n_bar_open;
    logic [mbb_pkg::PORT_PRICE_W-1:0] r_bar_high, n_bar_high;
    logic [mbb_pkg::PORT_PRICE_W-1:0] r_bar_low, n_bar_low;
    logic [mbb_pkg::PORT_PRICE_W-1:0] r_bar_close, n_bar_close;
    logic [mbb_pkg::VOL_W-1:0]       r_bar_volume, n_bar_volume;
    logic                            r_bar_seen, n_bar_seen;
    logic                            r_bar_last, n_bar_last;

    logic                            acc;
    logic                            in_range;
    logic                            roll;
    mbb_pkg::t_idx                   acc_idx;
    mbb_pkg::t_idx                   next_idx;
    logic                            walk_seen;

    logic                            ram_we;
    mbb_pkg::t_idx                   ram_waddr;
    mbb_pkg::t_entry                 ram_wdata;
    logic                            ram_re;
    mbb_pkg::t_idx                   ram_raddr;
    mbb_pkg::t_entry                 ram_rdata;

    logic                            use_seed;
    mbb_pkg::t_entry                 calc_base;
    mbb_pkg::t_entry                 calc_update;
    mbb_pkg::t_entry                 calc_reseed;
    logic [mbb_pkg::VOL_W-1:0]       calc_volume;

    mbb_ram #(
        .WIDTH (mbb_pkg::ENTRY_W),
        .DEPTH (mbb_pkg::INSTRUMENTS)
    ) u_bar_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    mbb_bar_calc u_calc (
        .i_entry    (ram_rdata),
        .i_tick     (r_tick),
        .i_use_seed (use_seed),
        .o_base     (calc_base),
        .o_update   (calc_update),
        .o_reseed   (calc_reseed),
        .o_volume   (calc_volume)
    );

    assign busy     = (r_state != mbb_pkg::ST_IDLE);
    assign acc      = start && !busy;
    assign in_range = (32'(i_instrument) < 32'(mbb_pkg::INSTRUMENTS));
    assign acc_idx  = mbb_pkg::IDX_W'(i_instrument);
    assign roll     = mbb_pkg::is_rollover(r_cur, i_tick_minute);
    assign next_idx = mbb_pkg::IDX_W'(32'(r_idx) + 32'd1);

    always_comb begin
        n_state          = r_state;
        n_seen           = r_seen;
        n_cur            = r_cur;
        n_idx            = r_idx;
        n_tick           = r_tick;
        n_tick_idx       = r_tick_idx;
        n_seed_hit       = r_seed_hit;
        n_was_seen       = r_was_seen;
        n_same           = r_same;
        n_bar_strobe     = 1'b0;
        n_bar_instrument = r_bar_instrument;
        n_bar_minute     = r_bar_minute;
        n_bar_open       = r_bar_open;
        n_bar_high       = r_bar_high;
        n_bar_low        = r_bar_low;
        n_bar_close      = r_bar_close;
        n_bar_volume     = r_bar_volume;
        n_bar_seen       = r_bar_seen;
        n_bar_last       = r_bar_last;
        ram_we           = 1'b0;
        ram_waddr        = r_idx;
        ram_wdata        = calc_reseed;
        ram_re           = 1'b0;
        ram_raddr        = acc_idx;
        use_seed         = 1'b0;
        walk_seen        = r_seen[r_idx];

        case (r_state)
            mbb_pkg::ST_IDLE: begin
                if (i_cfg_we) begin
                    n_cur = i_cfg_wdata;
                end
                if (acc && in_range) begin
                    n_tick.price  = mbb_pkg::PRICE_BITS'(i_tick_price);
                    n_tick.volume = i_tick_total_volume;
                    n_tick.minute = i_tick_minute;
                    n_tick_idx    = acc_idx;
                    n_seen[acc_idx] = 1'b1;
                    ram_re        = 1'b1;
                    if (roll) begin
                        // seeded entry is overlaid during the walk
                        n_seed_hit = !r_seen[acc_idx];
                        ram_raddr  = '0;
                        n_idx      = '0;
                        n_state    = mbb_pkg::ST_WALK;
                    end else begin
                        ram_raddr  = acc_idx;
                        n_was_seen = r_seen[acc_idx];
                        n_same     = (r_cur == i_tick_minute);
                        n_state    = mbb_pkg::ST_UPDATE;
                    end
                end
            end
            mbb_pkg::ST_UPDATE: begin
                use_seed  = !r_was_seen;
                ram_waddr = r_tick_idx;
                ram_we    = !r_was_seen || r_same;
                ram_wdata = r_same ? calc_update : calc_base;
                n_state   = mbb_pkg::ST_IDLE;
            end
            mbb_pkg::ST_WALK: begin
                use_seed         = r_seed_hit && (r_idx == r_tick_idx);
                ram_waddr        = r_idx;
                ram_we           = walk_seen;
                ram_wdata        = calc_reseed;
                n_bar_strobe     = 1'b1;
                n_bar_instrument = mbb_pkg::INST_W'(r_idx);
                n_bar_minute     = r_cur;
                n_bar_open       = walk_seen ? mbb_pkg::PORT_PRICE_W'(calc_base.open)  : '0;
                n_bar_high       = walk_seen ? mbb_pkg::PORT_PRICE_W'(calc_base.high)  : '0;
                n_bar_low        = walk_seen ? mbb_pkg::PORT_PRICE_W'(calc_base.low)   : '0;
                n_bar_close      = walk_seen ? mbb_pkg::PORT_PRICE_W'(calc_base.close) : '0;
                n_bar_volume     = walk_seen ? calc_volume : '0;
                n_bar_seen       = walk_seen;
                n_bar_last       = (r_idx == LAST_IDX);
                if (r_idx == LAST_IDX) begin
                    n_cur   = r_tick.minute;
                    n_state = mbb_pkg::ST_IDLE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = next_idx;
                    n_idx     = next_idx;
                end
            end
            default: begin
                n_state = mbb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen       <= '0;
            r_cur        <= '0;
            r_bar_strobe <= 1'b0;
        end else begin
            r_seen       <= n_seen;
            r_cur        <= n_cur;
            r_bar_strobe <= n_bar_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx            <= n_idx;
        r_tick           <= n_tick;
        r_tick_idx       <= n_tick_idx;
        r_seed_hit       <= n_seed_hit;
        r_was_seen       <= n_was_seen;
        r_same           <= n_same;
        r_bar_instrument <= n_bar_instrument;
        r_bar_minute     <= n_bar_minute;
        r_bar_open       <= n_bar_open;
        r_bar_high       <= n_bar_high;
        r_bar_low        <= n_bar_low;
        r_bar_close      <= n_bar_close;
        r_bar_volume     <= n_bar_volume;
        r_bar_seen       <= n_bar_seen;
        r_bar_last       <= n_bar_last;
    end

    assign o_bar_strobe     = r_bar_strobe;
    assign o_bar_instrument = r_bar_instrument;
    assign o_bar_minute     = r_bar_minute;
    assign o_bar_open       = r_bar_open;
    assign o_bar_high       = r_bar_high;
    assign o_bar_low        = r_bar_low;
    assign o_bar_close      = r_bar_close;
    assign o_bar_volume     = r_bar_volume;
    assign o_bar_seen       = r_bar_seen;
    assign o_bar_last       = r_bar_last;

    a_walk_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mbb_pkg::ST_WALK) |=> o_bar_strobe)
        else $error("walk cycle without bar beat");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_bar_strobe && o_bar_last) |=> !o_bar_strobe)
        else $error("bar beat after last of rollover");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_bar_strobe && !o_bar_last) |-> busy)
        else $error("idle in the middle of a rollover");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re && (ram_waddr == ram_raddr)))
        else $error("read and write of one entry in the same cycle");

    a_update_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mbb_pkg::ST_UPDATE) |=> (r_state == mbb_pkg::ST_IDLE))
        else $error("update took more than one cycle");

endmodule

`default_nettype wire

// ===== tb/sv/per_instrument_minute_bar_builder_unit_test.sv =====
`default_nettype none

typedef struct {
    logic [mbb_pkg::INST_W-1:0]       inst;
    logic [mbb_pkg::MIN_W-1:0]        minute;
    logic [mbb_pkg::PORT_PRICE_W-1:0] open_px;
    logic [mbb_pkg::PORT_PRICE_W-1:0] high_px;
    logic [mbb_pkg::PORT_PRICE_W-1:0] low_px;
    logic [mbb_pkg::PORT_PRICE_W-1:0] close_px;
    logic [mbb_pkg::VOL_W-1:0]        volume;
    logic                             seen;
    logic                             last;
} bar_t;

class minute_bar_book;
    logic [mbb_pkg::MIN_W-1:0]        cur_minute;
    bit                               seen[mbb_pkg::INSTRUMENTS];
    logic [mbb_pkg::PORT_PRICE_W-1:0] open_px[mbb_pkg::INSTRUMENTS];
    logic [mbb_pkg::PORT_PRICE_W-1:0] high_px[mbb_pkg::INSTRUMENTS];
    logic [mbb_pkg::PORT_PRICE_W-1:0] low_px[mbb_pkg::INSTRUMENTS];
    logic [mbb_pkg::PORT_PRICE_W-1:0] close_px[mbb_pkg::INSTRUMENTS];
    logic [mbb_pkg::VOL_W-1:0]        run_total[mbb_pkg::INSTRUMENTS];
    logic [mbb_pkg::VOL_W-1:0]        prev_total[mbb_pkg::INSTRUMENTS];
    logic [mbb_pkg::MIN_W-1:0]        open_min[mbb_pkg::INSTRUMENTS];
    logic [mbb_pkg::MIN_W-1:0]        close_min[mbb_pkg::INSTRUMENTS];
    bar_t                             pending_bars[$];
    int                               errors;

    function new();
        cur_minute = '0;
        errors = 0;
        for (int k = 0; k < mbb_pkg::INSTRUMENTS; k++) begin
            seen[k] = 0;
            open_px[k] = '0;
            high_px[k] = '0;
            low_px[k] = '0;
            close_px[k] = '0;
            run_total[k] = '0;
            prev_total[k] = '0;
            open_min[k] = '0;
            close_min[k] = '0;
        end
    endfunction

    function void load_start(logic [mbb_pkg::MIN_W-1:0] v);
        cur_minute = v;
    endfunction

    function bit starts_period(logic [mbb_pkg::MIN_W-1:0] cur,
                               logic [mbb_pkg::MIN_W-1:0] t);
        bit later;
        bit held;
        later = (cur < t) || (cur >= mbb_pkg::WRAP_FROM && t <= mbb_pkg::WRAP_TO);
        held  = (cur < mbb_pkg::NIGHT_END) && (t > mbb_pkg::DAY_END);
        return later && !held;
    endfunction

    function void note_tick(logic [mbb_pkg::INST_W-1:0] inst,
                            logic [mbb_pkg::PORT_PRICE_W-1:0] px,
                            logic [mbb_pkg::VOL_W-1:0] vol,
                            logic [mbb_pkg::MIN_W-1:0] t);
        bar_t b;
        if (!seen[inst]) begin
            seen[inst] = 1;
            open_px[inst] = px;
            high_px[inst] = px;
            low_px[inst] = px;
            close_px[inst] = px;
            run_total[inst] = vol;
            prev_total[inst] = vol;
            open_min[inst] = t;
            close_min[inst] = t;
        end
        if (starts_period(cur_minute, t)) begin
            for (int k = 0; k < mbb_pkg::INSTRUMENTS; k++) begin
                b.inst     = mbb_pkg::INST_W'(k);
                b.minute   = cur_minute;
                b.open_px  = seen[k] ? open_px[k] : '0;
                b.high_px  = seen[k] ? high_px[k] : '0;
                b.low_px   = seen[k] ? low_px[k] : '0;
                b.close_px = seen[k] ? close_px[k] : '0;
                b.volume   = seen[k] ? run_total[k] - prev_total[k] : '0;
                b.seen     = seen[k];
                b.last     = (k == mbb_pkg::INSTRUMENTS - 1);
                pending_bars = {pending_bars, b};
                prev_total[k] = run_total[k];
                open_px[k] = close_px[k];
                high_px[k] = close_px[k];
                low_px[k] = close_px[k];
                open_min[k] = close_min[k];
            end
            cur_minute = t;
        end else if (cur_minute == t) begin
            close_px[inst] = px;
            if (t != open_min[inst]) begin
                open_px[inst] = px;
                open_min[inst] = t;
            end
            if (px > high_px[inst]) high_px[inst] = px;
            if (px < low_px[inst]) low_px[inst] = px;
            run_total[inst] = vol;
            close_min[inst] = t;
        end
    endfunction

    task report_mismatch(string msg);
        errors++;
        if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    task check_bar(bar_t got);
        bar_t want;
        string tag;
        if (pending_bars.size() == 0) begin
            report_mismatch($sformatf("bar for instrument %0d with none expected", got.inst));
        end else begin
            want = pending_bars.pop_front();
            tag = $sformatf("bar inst %0d minute %0d:", want.inst, want.minute);
            if (got.inst !== want.inst)
                report_mismatch($sformatf("%s instrument got %0d", tag, got.inst));
            if (got.minute !== want.minute)
                report_mismatch($sformatf("%s minute got %0d", tag, got.minute));
            if (got.open_px !== want.open_px)
                report_mismatch($sformatf("%s open got %h want %h", tag, got.open_px,
                                          want.open_px));
            if (got.high_px !== want.high_px)
                report_mismatch($sformatf("%s high got %h want %h", tag, got.high_px,
                                          want.high_px));
            if (got.low_px !== want.low_px)
                report_mismatch($sformatf("%s low got %h want %h", tag, got.low_px,
                                          want.low_px));
            if (got.close_px !== want.close_px)
                report_mismatch($sformatf("%s close got %h want %h", tag, got.close_px,
                                          want.close_px));
            if (got.volume !== want.volume)
                report_mismatch($sformatf("%s volume got %h want %h", tag, got.volume,
                                          want.volume));
            if (got.seen !== want.seen)
                report_mismatch($sformatf("%s seen got %b", tag, got.seen));
            if (got.last !== want.last)
                report_mismatch($sformatf("%s last got %b", tag, got.last));
        end
    endtask
endclass

module per_instrument_minute_bar_builder_unit_test;

    localparam int CYCLE_LIMIT = 400000;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              start;
    logic                              busy;
    logic                              i_cfg_we;
    logic [mbb_pkg::MIN_W-1:0]         i_cfg_wdata;
    logic [mbb_pkg::INST_W-1:0]        i_instrument;
    logic [mbb_pkg::PORT_PRICE_W-1:0]  i_tick_price;
    logic [mbb_pkg::VOL_W-1:0]         i_tick_total_volume;
    logic [mbb_pkg::MIN_W-1:0]         i_tick_minute;
    logic                              o_bar_strobe;
    logic [mbb_pkg::INST_W-1:0]        o_bar_instrument;
    logic [mbb_pkg::MIN_W-1:0]         o_bar_minute;
    logic [mbb_pkg::PORT_PRICE_W-1:0]  o_bar_open;
    logic [mbb_pkg::PORT_PRICE_W-1:0]  o_bar_high;
    logic [mbb_pkg::PORT_PRICE_W-1:0]  o_bar_low;
    logic [mbb_pkg::PORT_PRICE_W-1:0]  o_bar_close;
    logic [mbb_pkg::VOL_W-1:0]         o_bar_volume;
    logic                              o_bar_seen;
    logic                              o_bar_last;

    minute_bar_book                    book;
    bar_t                              seen_bar;
    int                                burst_left;
    logic [mbb_pkg::INST_W-1:0]        hot_base;
    logic [mbb_pkg::VOL_W-1:0]         last_vol[mbb_pkg::INSTRUMENTS];
    logic [mbb_pkg::PORT_PRICE_W-1:0]  last_px[mbb_pkg::INSTRUMENTS];
    int                                phase_start[6] = '{0, 1439, 175, 1437, 1000, 0};

    per_instrument_minute_bar_builder_unit DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_instrument        (i_instrument),
        .i_tick_price        (i_tick_price),
        .i_tick_total_volume (i_tick_total_volume),
        .i_tick_minute       (i_tick_minute),
        .o_bar_strobe        (o_bar_strobe),
        .o_bar_instrument    (o_bar_instrument),
        .o_bar_minute        (o_bar_minute),
        .o_bar_open          (o_bar_open),
        .o_bar_high          (o_bar_high),
        .o_bar_low           (o_bar_low),
        .o_bar_close         (o_bar_close),
        .o_bar_volume        (o_bar_volume),
        .o_bar_seen          (o_bar_seen),
        .o_bar_last          (o_bar_last)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // bar beats checked before the tick beat of the same edge is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_bar_strobe === 1'b1) begin
                seen_bar.inst     = o_bar_instrument;
                seen_bar.minute   = o_bar_minute;
                seen_bar.open_px  = o_bar_open;
                seen_bar.high_px  = o_bar_high;
                seen_bar.low_px   = o_bar_low;
                seen_bar.close_px = o_bar_close;
                seen_bar.volume   = o_bar_volume;
                seen_bar.seen     = o_bar_seen;
                seen_bar.last     = o_bar_last;
                book.check_bar(seen_bar);
            end else if (o_bar_strobe !== 1'b0) begin
                book.report_mismatch("bar strobe unknown");
            end
            if (i_cfg_we) book.load_start(i_cfg_wdata);
            if (start && busy === 1'b0)
                book.note_tick(i_instrument, i_tick_price, i_tick_total_volume, i_tick_minute);
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("simulation failed");
        $finish;
    end

    // leaves the caller at a falling edge, after any gap between bursts
    task automatic wait_slot();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 50)
                                                     : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                start = 1'b0;
                i_instrument = mbb_pkg::INST_W'($urandom);
                i_tick_price = $urandom;
                i_tick_total_volume = $urandom;
                i_tick_minute = mbb_pkg::MIN_W'($urandom);
                i_cfg_wdata = mbb_pkg::MIN_W'($urandom);
            end
        end
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic drive_tick(input logic [mbb_pkg::INST_W-1:0] inst,
                              input logic [mbb_pkg::PORT_PRICE_W-1:0] px,
                              input logic [mbb_pkg::VOL_W-1:0] vol,
                              input logic [mbb_pkg::MIN_W-1:0] t);
        i_instrument = inst;
        i_tick_price = px;
        i_tick_total_volume = vol;
        i_tick_minute = t;
        start = 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic send_tick(input logic [mbb_pkg::INST_W-1:0] inst,
                             input logic [mbb_pkg::PORT_PRICE_W-1:0] px,
                             input logic [mbb_pkg::VOL_W-1:0] vol,
                             input logic [mbb_pkg::MIN_W-1:0] t);
        wait_slot();
        drive_tick(inst, px, vol, t);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (book.pending_bars.size() != 0 || busy !== 1'b0);
    endtask

    task automatic write_start(input logic [mbb_pkg::MIN_W-1:0] v);
        @(negedge i_clk);
        start = 1'b0;
        wait_drained();
        // a plain update may still be writing its entry
        repeat (4) @(negedge i_clk);
        i_cfg_wdata = v;
        i_cfg_we = 1'b1;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        burst_left = 0;
    endtask

    task automatic send_random_tick();
        logic [mbb_pkg::INST_W-1:0]       inst;
        logic [mbb_pkg::PORT_PRICE_W-1:0] px;
        logic [mbb_pkg::VOL_W-1:0]        vol;
        logic [mbb_pkg::MIN_W-1:0]        cur;
        logic [mbb_pkg::MIN_W-1:0]        t;
        int                               r;
        int                               pr;
        wait_slot();
        cur = book.cur_minute;
        inst = $urandom_range(0, 1) ? mbb_pkg::INST_W'(hot_base + $urandom_range(0, 3))
                                    : mbb_pkg::INST_W'($urandom_range(0, 63));
        r = $urandom_range(0, 99);
        if (r < 70) begin
            t = cur;
        end else if (r < 82) begin
            if (cur >= mbb_pkg::WRAP_FROM) t = mbb_pkg::MIN_W'($urandom_range(0, 1));
            else if (r < 80) t = cur + 11'd1;
            else t = mbb_pkg::MIN_W'(cur + $urandom_range(2, 20));
        end else if (r < 88) begin
            t = (cur == 0) ? cur : mbb_pkg::MIN_W'($urandom_range(0, cur - 1));
        end else if (r < 94) begin
            t = mbb_pkg::MIN_W'($urandom_range(931, 1439));
        end else begin
            t = mbb_pkg::MIN_W'($urandom_range(0, 2047));
        end
        pr = $urandom_range(0, 19);
        if (pr == 0) px = '0;
        else if (pr == 1) px = '1;
        else if (pr < 12) px = last_px[inst] + $urandom_range(0, 255) - 128;
        else px = $urandom;
        last_px[inst] = px;
        vol = ($urandom_range(0, 19) == 0) ? $urandom : last_vol[inst] + $urandom_range(0, 5000);
        last_vol[inst] = vol;
        drive_tick(inst, px, vol, t);
    endtask

    initial begin
        book = new();
        burst_left = 0;
        hot_base = '0;
        for (int k = 0; k < mbb_pkg::INSTRUMENTS; k++) begin
            last_vol[k] = '0;
            last_px[k] = 32'd100000;
        end
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_instrument = '0;
        i_tick_price = '0;
        i_tick_total_volume = '0;
        i_tick_minute = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_tick(6'd0, 32'h0000_0000, 32'h0000_0000, 11'd0);
        send_tick(6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd0);
        send_tick(6'd0, 32'hFFFF_FFFF, 32'd5, 11'd0);
        send_tick(6'd63, 32'h0000_0000, 32'd3, 11'd0);
        send_tick(6'd0, 32'h8000_0000, 32'd7, 11'd0);
        // unseen instrument seeds and then rolls the minute over
        send_tick(6'd5, 32'd1234, 32'd100, 11'd1);
        send_tick(6'd5, 32'd999, 32'd150, 11'd0);
        // seeded from an older tick, open replaced on the next minute
        send_tick(6'd7, 32'd4242, 32'd10, 11'd0);
        send_tick(6'd7, 32'd4343, 32'd20, 11'd1);
        send_tick(6'd63, 32'd1, 32'd8, 11'd1);
        write_start(11'd170);
        send_tick(6'd1, 32'd55, 32'd1, 11'd1000);
        send_tick(6'd1, 32'd60, 32'd2, 11'd170);
        send_tick(6'd2, 32'd70, 32'd3, 11'd171);
        write_start(11'd1439);
        send_tick(6'd3, 32'd80, 32'd4, 11'd0);
        write_start(11'd1437);
        send_tick(6'd3, 32'd81, 32'd5, 11'd0);
        send_tick(6'd3, 32'd82, 32'd6, 11'd1437);
        send_tick(6'd4, 32'd90, 32'd7, 11'd1438);
        send_tick(6'd4, 32'd91, 32'd8, 11'd2047);
        send_tick(6'd4, 32'd92, 32'd9, 11'd0);
        write_start(11'd179);
        send_tick(6'd6, 32'd100, 32'd10, 11'd931);
        send_tick(6'd6, 32'd101, 32'd11, 11'd930);
        write_start(11'd180);
        send_tick(6'd6, 32'd102, 32'd12, 11'd931);

        for (int p = 0; p < 6; p++) begin
            write_start(mbb_pkg::MIN_W'((p == 5) ? $urandom_range(0, 1439) : phase_start[p]));
            hot_base = mbb_pkg::INST_W'($urandom_range(0, 63));
            repeat (77) send_random_tick();
        end

        @(negedge i_clk);
        start = 1'b0;
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (book.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
sv/mbb_pkg.sv
sv/mbb_ram.sv
sv/mbb_bar_calc.sv
sv/per_instrument_minute_bar_builder_unit.sv
tb/sv/per_instrument_minute_bar_builder_unit_test.sv
